[hw/rtl/gbs_pkg.sv]
// Shared types, constants and codes for the greedy box suppression block.
package gbs_pkg;

	localparam int MAX_BOXES  = 64;
	localparam int COORD_BITS = 12;
	localparam int CNT_W      = $clog2(MAX_BOXES + 1);
	localparam int IDX_W      = 6;
	localparam int SCORE_W    = 16;
	localparam int SIZE_W     = COORD_BITS + 1;
	localparam int END_W      = COORD_BITS + 2;
	localparam int AREA_W     = 2 * SIZE_W;
	localparam int UNI_W      = AREA_W + 1;
	localparam int CMP_W      = UNI_W + SCORE_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CALC_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_THR = 2'd1;
	localparam logic [CALC_W-1:0]    CALC_LAT        = 3'd4;

	typedef struct packed {
		logic [11:0] box_left;
		logic [11:0] box_top;
		logic [12:0] box_width;
		logic [12:0] box_height;
		logic [15:0] box_score;
		logic        final_box;
	} box_t;

	typedef struct packed {
		logic [5:0] kept_index;
		logic       index_valid;
		logic       end_of_list;
		logic       overflowed;
	} result_t;

	typedef struct packed {
		logic                  valid;
		logic                  live;
		logic                  done;
		logic [IDX_W-1:0]      idx;
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] top;
		logic [SIZE_W-1:0]     width;
		logic [SIZE_W-1:0]     height;
		logic [SCORE_W-1:0]    score;
	} entry_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_ROTATE,
		OP_MARK,
		OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [SCORE_W-1:0] thr;
		entry_t             new_entry;
		entry_t             wrap;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_MARK,
		ST_HEAD,
		ST_SWEEP,
		ST_CALC,
		ST_SKIP,
		ST_FINISH
	} state_t;

endpackage

[hw/rtl/gbs_cell.sv]
// One chain cell: holds a box for sorting, rotation, marking and clearing.
module gbs_cell import gbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      is_last,
	input  entry_t    left_entry,
	input  logic      left_ge,
	input  entry_t    right_entry,
	output entry_t    entry,
	output logic      ge
);

	entry_t entry_q;
	entry_t entry_d;

	assign entry = entry_q;
	assign ge    = entry_q.valid && (entry_q.score >= ctl.new_entry.score);

	always_comb begin
		entry_d = entry_q;
		case (ctl.op)
			OP_INSERT: begin
				if (!ge) begin
					entry_d = left_ge ? ctl.new_entry : left_entry;
				end
			end
			OP_ROTATE: begin
				entry_d = is_last ? ctl.wrap : right_entry;
			end
			OP_MARK: begin
				entry_d.live = entry_q.valid && (entry_q.score >= ctl.thr);
				entry_d.done = 1'b0;
			end
			OP_CLEAR: begin
				entry_d.valid = 1'b0;
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_d;
		end
	end

endmodule

[hw/rtl/gbs_iou.sv]
// Pipelined overlap test of the chain head against the current kept box.
module gbs_iou import gbs_pkg::*; (
	input  logic               clk,
	input  entry_t             keeper,
	input  logic [AREA_W-1:0]  keeper_area,
	input  entry_t             cand,
	input  logic [SCORE_W-1:0] thr,
	output logic               suppress
);

	logic [END_W-1:0]  ka_x1, ka_y1, kb_x1, kb_y1, x0, y0, x1, y1;
	logic [END_W-1:0]  dx, dy;
	logic [SIZE_W-1:0] iw_s1, ih_s1;
	logic [AREA_W-1:0] br_s1, br_s2, inter_s2, inter_s3;
	logic [UNI_W-1:0]  uni_s3;
	logic [CMP_W-1:0]  lhs, rhs;
	logic              supp_s4;

	assign ka_x1 = END_W'(keeper.left) + END_W'(keeper.width);
	assign ka_y1 = END_W'(keeper.top) + END_W'(keeper.height);
	assign kb_x1 = END_W'(cand.left) + END_W'(cand.width);
	assign kb_y1 = END_W'(cand.top) + END_W'(cand.height);
	assign x0 = (keeper.left > cand.left) ? END_W'(keeper.left) : END_W'(cand.left);
	assign y0 = (keeper.top > cand.top) ? END_W'(keeper.top) : END_W'(cand.top);
	assign x1 = (ka_x1 < kb_x1) ? ka_x1 : kb_x1;
	assign y1 = (ka_y1 < kb_y1) ? ka_y1 : kb_y1;
	assign dx = x1 - x0;
	assign dy = y1 - y0;

	assign lhs = {{(CMP_W-AREA_W-SCORE_W){1'b0}}, inter_s3, {SCORE_W{1'b0}}};
	assign rhs = CMP_W'(thr) * CMP_W'(uni_s3);

	always_ff @(posedge clk) begin
		if ((x1 > x0) && (y1 > y0)) begin
			iw_s1 <= dx[SIZE_W-1:0];
			ih_s1 <= dy[SIZE_W-1:0];
		end else begin
			iw_s1 <= '0;
			ih_s1 <= '0;
		end
		br_s1    <= AREA_W'(cand.width) * AREA_W'(cand.height);
		inter_s2 <= AREA_W'(iw_s1) * AREA_W'(ih_s1);
		br_s2    <= br_s1;
		uni_s3   <= UNI_W'(keeper_area) + UNI_W'(br_s2) - UNI_W'(inter_s2);
		inter_s3 <= inter_s2;
		supp_s4  <= (uni_s3 != '0) && (lhs > rhs);
	end

	assign suppress = supp_s4;

endmodule

[hw/rtl/greedy_box_suppression_top.sv]
// Top level of the greedy box suppression block: sequencer, cell chain and overlap unit.
//
// Boxes arrive one per transfer on start/busy with the payload on box; a transfer
// happens at a rising edge where start is high and busy is low. Boxes are sorted
// by descending score into a chain of MAX_BOXES cells as they arrive. The box
// marked final_box starts suppression, during which busy is high.
// Suppression walks the chain by rotation, rank by rank, and each kept box sweeps
// the other boxes: a box already out is rotated past, and a box that needs an
// overlap test waits on the multiplier pipeline before it is rotated.
// Each result appears for one cycle with result_strobe high; the receiver cannot
// stall, and the last result of a set carries end_of_list. Boxes beyond capacity
// are dropped and flagged as overflowed.
// Thresholds are written on cfg_valid/cfg_ready, which is always ready, and must
// only change while busy is low and no set is part-way through.
// Reset clears the chain, the box count, the overflow flag and both thresholds.
module greedy_box_suppression_top import gbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  box_t                 box,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCORE_W-1:0]   cfg_data,
	output logic                 result_strobe,
	output result_t              result
);

	state_t state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d, rank_q, rank_d, sweep_q, sweep_d;
	logic [CALC_W-1:0]  calc_q, calc_d;
	logic               ovf_q, ovf_d, pend_valid_q, pend_valid_d;
	logic [IDX_W-1:0]   pend_q, pend_d;
	logic               strobe_q, strobe_d, keeper_load;
	result_t            result_q, result_d;
	logic [SCORE_W-1:0] score_thr_q, overlap_thr_q;
	entry_t             keeper_q;
	logic [AREA_W-1:0]  keeper_area_q;
	cell_ctl_t          ctl;
	entry_t             entries [MAX_BOXES];
	logic               ges [MAX_BOXES];
	entry_t             head;
	logic               suppress;

	assign head          = entries[0];
	assign cfg_ready     = 1'b1;
	assign busy          = (state_q != ST_LOAD) || strobe_q;
	assign result_strobe = strobe_q;
	assign result        = result_q;

	for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
		gbs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.is_last    (count_q == CNT_W'(i + 1)),
			.left_entry ((i == 0) ? ctl.new_entry : entries[(i == 0) ? 0 : i - 1]),
			.left_ge    ((i == 0) ? 1'b1 : ges[(i == 0) ? 0 : i - 1]),
			.right_entry((i == MAX_BOXES - 1) ? ctl.wrap
				: entries[(i == MAX_BOXES - 1) ? i : i + 1]),
			.entry      (entries[i]),
			.ge         (ges[i])
		);
	end

	gbs_iou u_iou (
		.clk        (clk),
		.keeper     (keeper_q),
		.keeper_area(keeper_area_q),
		.cand       (head),
		.thr        (overlap_thr_q),
		.suppress   (suppress)
	);

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		rank_d       = rank_q;
		sweep_d      = sweep_q;
		calc_d       = calc_q;
		ovf_d        = ovf_q;
		pend_d       = pend_q;
		pend_valid_d = pend_valid_q;
		strobe_d     = 1'b0;
		result_d     = result_q;
		keeper_load  = 1'b0;

		ctl.op                  = OP_HOLD;
		ctl.thr                 = score_thr_q;
		ctl.new_entry.valid     = 1'b1;
		ctl.new_entry.live      = 1'b0;
		ctl.new_entry.done      = 1'b0;
		ctl.new_entry.idx       = IDX_W'(count_q);
		ctl.new_entry.left      = box.box_left[COORD_BITS-1:0];
		ctl.new_entry.top       = box.box_top[COORD_BITS-1:0];
		ctl.new_entry.width     = box.box_width[SIZE_W-1:0];
		ctl.new_entry.height    = box.box_height[SIZE_W-1:0];
		ctl.new_entry.score     = box.box_score;
		ctl.wrap                = head;

		case (state_q)
			ST_LOAD: begin
				if (start && !strobe_q) begin
					if (count_q < CNT_W'(MAX_BOXES)) begin
						ctl.op  = OP_INSERT;
						count_d = count_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					if (box.final_box) begin
						state_d = ST_MARK;
					end
				end
			end
			ST_MARK: begin
				ctl.op       = OP_MARK;
				rank_d       = '0;
				pend_valid_d = 1'b0;
				state_d      = ST_HEAD;
			end
			ST_HEAD: begin
				if (rank_q == count_q) begin
					state_d = ST_FINISH;
				end else begin
					ctl.op        = OP_ROTATE;
					ctl.wrap.done = 1'b1;
					rank_d        = rank_q + 1'b1;
					if (head.live) begin
						keeper_load = 1'b1;
						if (pend_valid_q) begin
							strobe_d             = 1'b1;
							result_d.kept_index  = pend_q;
							result_d.index_valid = 1'b1;
							result_d.end_of_list = 1'b0;
							result_d.overflowed  = ovf_q;
						end
						pend_d       = head.idx;
						pend_valid_d = 1'b1;
						sweep_d      = count_q - 1'b1;
						state_d      = ST_SWEEP;
					end
				end
			end
			ST_SWEEP: begin
				if (sweep_q == '0) begin
					state_d = ST_SKIP;
				end else if (head.done || !head.live) begin
					ctl.op  = OP_ROTATE;
					sweep_d = sweep_q - 1'b1;
				end else begin
					calc_d  = '0;
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				calc_d = calc_q + 1'b1;
				if (calc_q == CALC_LAT) begin
					ctl.op        = OP_ROTATE;
					ctl.wrap.live = !suppress;
					sweep_d       = sweep_q - 1'b1;
					state_d       = ST_SWEEP;
				end
			end
			ST_SKIP: begin
				ctl.op  = OP_ROTATE;
				state_d = ST_HEAD;
			end
			ST_FINISH: begin
				ctl.op               = OP_CLEAR;
				strobe_d             = 1'b1;
				result_d.kept_index  = pend_valid_q ? pend_q : '0;
				result_d.index_valid = pend_valid_q;
				result_d.end_of_list = 1'b1;
				result_d.overflowed  = ovf_q;
				count_d              = '0;
				ovf_d                = 1'b0;
				pend_valid_d         = 1'b0;
				state_d              = ST_LOAD;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			count_q      <= '0;
			rank_q       <= '0;
			sweep_q      <= '0;
			calc_q       <= '0;
			ovf_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
			score_thr_q  <= '0;
			overlap_thr_q <= '0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			rank_q       <= rank_d;
			sweep_q      <= sweep_d;
			calc_q       <= calc_d;
			ovf_q        <= ovf_d;
			pend_valid_q <= pend_valid_d;
			strobe_q     <= strobe_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SCORE_THR) begin
					score_thr_q <= cfg_data;
				end else if (cfg_index == REG_OVERLAP_THR) begin
					overlap_thr_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q   <= pend_d;
		result_q <= result_d;
		if (keeper_load) begin
			keeper_q      <= head;
			keeper_area_q <= AREA_W'(head.width) * AREA_W'(head.height);
		end
	end

endmodule

[hw/rtl/gbs_checker.sv]
// Port-level checks on the greedy box suppression block, bound to its top level.
module gbs_checker import gbs_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input box_t    box,
	input logic    result_strobe,
	input result_t result
);

	a_final_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && box.final_box |=> busy)
		else $error("Final box transfer did not start suppression.");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("Result shown while the block reports idle.");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.index_valid |-> result.end_of_list)
		else $error("Empty result was not the last of its set.");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.end_of_list |=> !result_strobe)
		else $error("Result followed the end of list directly.");

endmodule

bind greedy_box_suppression_top gbs_checker u_gbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.box          (box),
	.result_strobe(result_strobe),
	.result       (result)
);

[verif/greedy_box_suppression_top_tb.sv]
// Self-checking testbench for the greedy box suppression block, with a built-in predictor.
module greedy_box_suppression_top_tb import gbs_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int STALL_LIMIT = 100000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		box_t    b;
		bit      typed;
		result_t res;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	box_t                 box;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SCORE_W-1:0]   cfg_data;
	logic                 result_strobe;
	result_t              result;

	box_t       held_boxes[$];
	bit         set_overflow;
	bit [15:0]  score_thr;
	bit [15:0]  overlap_thr;
	result_t    kept_expected[$];
	int         mismatches;
	int         stall_cycles;
	bit         no_gaps;

	greedy_box_suppression_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.box(box),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.result(result)
	);

	always #1 clk = ~clk;

	function automatic bit too_much_overlap(box_t a, box_t b);
		longint unsigned area_a, area_b, inter, uni, x0, y0, x1, y1;
		longint unsigned ax1, ay1, bx1, by1;
		area_a = longint'(a.box_width) * a.box_height;
		area_b = longint'(b.box_width) * b.box_height;
		ax1 = longint'(a.box_left) + a.box_width;
		ay1 = longint'(a.box_top) + a.box_height;
		bx1 = longint'(b.box_left) + b.box_width;
		by1 = longint'(b.box_top) + b.box_height;
		x0 = (a.box_left > b.box_left) ? a.box_left : b.box_left;
		y0 = (a.box_top > b.box_top) ? a.box_top : b.box_top;
		x1 = (ax1 < bx1) ? ax1 : bx1;
		y1 = (ay1 < by1) ? ay1 : by1;
		inter = 0;
		if (x1 > x0 && y1 > y0) begin
			inter = (x1 - x0) * (y1 - y0);
		end
		uni = area_a + area_b - inter;
		if (uni == 0) begin
			return 1'b0;
		end
		return (inter << 16) > longint'(overlap_thr) * uni;
	endfunction

	// Updates the held set with one accepted box and, on the final box, queues the kept list.
	function automatic void collect_box(box_t b, bit typed, result_t res);
		int      rank[$];
		bit      gone[64];
		int      j;
		int      kept;
		result_t r;
		if (held_boxes.size() < MAX_BOXES) begin
			held_boxes = {held_boxes, b};
		end else begin
			set_overflow = 1'b1;
		end
		if (!b.final_box) begin
			return;
		end
		for (int i = 0; i < held_boxes.size(); i++) begin
			if (held_boxes[i].box_score >= score_thr) begin
				j = rank.size();
				while (j > 0 && held_boxes[rank[j-1]].box_score < held_boxes[i].box_score) begin
					j--;
				end
				rank.insert(j, i);
			end
		end
		kept = 0;
		for (int i = 0; i < rank.size(); i++) begin
			if (!gone[i]) begin
				r.kept_index  = rank[i][5:0];
				r.index_valid = 1'b1;
				r.end_of_list = 1'b0;
				r.overflowed  = set_overflow;
				kept_expected = {kept_expected, r};
				kept++;
				for (int k = i + 1; k < rank.size(); k++) begin
					if (!gone[k] && too_much_overlap(held_boxes[rank[i]], held_boxes[rank[k]])) begin
						gone[k] = 1'b1;
					end
				end
			end
		end
		if (kept == 0) begin
			r = '{kept_index: 6'd0, index_valid: 1'b0, end_of_list: 1'b1,
				overflowed: set_overflow};
			kept_expected = {kept_expected, r};
		end else begin
			kept_expected[kept_expected.size()-1].end_of_list = 1'b1;
		end
		if (typed) begin
			kept_expected[kept_expected.size()-1] = res;
		end
		held_boxes.delete();
		set_overflow = 1'b0;
	endfunction

	task automatic send_box(box_t b, bit typed = 1'b0, result_t res = '0);
		if (!no_gaps && $urandom_range(0, 99) < 25) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		box   <= b;
		do @(posedge clk); while (busy);
		collect_box(b, typed, res);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCORE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_SCORE_THR) begin
			score_thr = val;
		end else if (idx == REG_OVERLAP_THR) begin
			overlap_thr = val;
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		while (kept_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic box_t clustered_box(int cx, int cy, bit last);
		box_t b;
		if ($urandom_range(0, 9) == 0) begin
			b = box_t'($bits(box_t)'({$urandom, $urandom, $urandom}));
		end else begin
			b.box_left   = 12'((cx + $urandom_range(0, 40)) & 12'hFFF);
			b.box_top    = 12'((cy + $urandom_range(0, 40)) & 12'hFFF);
			b.box_width  = 13'($urandom_range(1, 200));
			b.box_height = 13'($urandom_range(1, 200));
			b.box_score  = 16'($urandom);
		end
		b.final_box = last;
		return b;
	endfunction

	task automatic random_sets(int items, int max_set);
		int n, cx, cy, sent;
		sent = 0;
		while (sent < items) begin
			n  = $urandom_range(1, max_set);
			cx = $urandom_range(0, 4095);
			cy = $urandom_range(0, 4095);
			for (int i = 0; i < n; i++) begin
				send_box(clustered_box(cx, cy, i == n - 1));
			end
			sent += n;
		end
	endtask

	always @(posedge clk) begin
		if (result_strobe) begin
			if (kept_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Unexpected result %p", result);
				end
			end else begin
				if (result.kept_index !== kept_expected[0].kept_index ||
						result.index_valid !== kept_expected[0].index_valid ||
						result.end_of_list !== kept_expected[0].end_of_list ||
						result.overflowed !== kept_expected[0].overflowed) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Result mismatch: expected %p, got %p", kept_expected[0], result);
					end
				end
				void'(kept_expected.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles > STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		arst_n       = 1'b0;
		start        = 1'b0;
		box          = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		mismatches   = 0;
		stall_cycles = 0;
		set_overflow = 1'b0;
		score_thr    = '0;
		overlap_thr  = '0;
		no_gaps      = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_SCORE_THR, 16'h0100);
		write_reg(REG_OVERLAP_THR, 16'h8000);
		write_reg(REG_SPARE_A, 16'hFFFF);
		write_reg(REG_SPARE_B, 16'h1234);

		rows = '{
			'{'{12'd0, 12'd0, 13'd1, 13'd1, 16'hFFFF, 1'b1}, 1'b1, '{6'd0, 1'b1, 1'b1, 1'b0}},
			'{'{12'd4095, 12'd4095, 13'd4096, 13'd4096, 16'h0100, 1'b1}, 1'b1,
				'{6'd0, 1'b1, 1'b1, 1'b0}},
			'{'{12'd0, 12'd0, 13'd1, 13'd1, 16'h00FF, 1'b1}, 1'b1, '{6'd0, 1'b0, 1'b1, 1'b0}},
			'{'{12'd10, 12'd10, 13'd100, 13'd100, 16'h9000, 1'b0}, 1'b0, '0},
			'{'{12'd10, 12'd10, 13'd100, 13'd100, 16'hA000, 1'b0}, 1'b0, '0},
			'{'{12'd500, 12'd500, 13'd50, 13'd50, 16'h9000, 1'b0}, 1'b0, '0},
			'{'{12'd20, 12'd20, 13'd100, 13'd90, 16'h9000, 1'b0}, 1'b0, '0},
			'{'{12'd0, 12'd0, 13'd1, 13'd1, 16'h0000, 1'b1}, 1'b0, '0},
			'{'{12'd5, 12'd5, 13'd0, 13'd10, 16'h8000, 1'b0}, 1'b0, '0},
			'{'{12'd5, 12'd5, 13'd0, 13'd10, 16'h8000, 1'b0}, 1'b0, '0},
			'{'{12'd5, 12'd5, 13'd10, 13'd0, 16'h8000, 1'b1}, 1'b0, '0},
			'{'{12'd100, 12'd100, 13'd10, 13'd10, 16'h7000, 1'b0}, 1'b0, '0},
			'{'{12'd300, 12'd300, 13'd10, 13'd10, 16'h7000, 1'b0}, 1'b0, '0},
			'{'{12'd4000, 12'd0, 13'd4096, 13'd8191, 16'hFFFF, 1'b0}, 1'b0, '0},
			'{'{12'd4000, 12'd0, 13'd4096, 13'd8191, 16'hFFFF, 1'b1}, 1'b0, '0},
			'{'{12'd2730, 12'd1365, 13'd5461, 13'd2730, 16'h5555, 1'b0}, 1'b0, '0},
			'{'{12'd1365, 12'd2730, 13'd2730, 13'd5461, 16'hAAAA, 1'b1}, 1'b0, '0}
		};
		foreach (rows[i]) begin
			send_box(rows[i].b, rows[i].typed, rows[i].res);
		end
		settle();

		write_reg(REG_SCORE_THR, 16'h0000);
		write_reg(REG_OVERLAP_THR, 16'h0000);
		no_gaps = 1'b1;
		random_sets(20, 6);
		no_gaps = 1'b0;
		settle();

		write_reg(REG_SCORE_THR, 16'hFFFF);
		write_reg(REG_OVERLAP_THR, 16'hFFFF);
		random_sets(10, 4);
		send_box('{12'd7, 12'd7, 13'd9, 13'd9, 16'hFFFF, 1'b0});
		send_box('{12'd7, 12'd7, 13'd9, 13'd9, 16'hFFFF, 1'b1});
		settle();

		write_reg(REG_SCORE_THR, 16'h4000);
		write_reg(REG_OVERLAP_THR, 16'h6000);
		random_sets(20, 8);
		for (int i = 0; i < MAX_BOXES + 2; i++) begin
			send_box(clustered_box(1000, 1000, i == MAX_BOXES + 1));
		end
		settle();

		write_reg(REG_SCORE_THR, 16'($urandom));
		write_reg(REG_OVERLAP_THR, 16'($urandom));
		random_sets(15, 8);
		settle();

		write_reg(REG_SCORE_THR, 16'h0000);
		write_reg(REG_OVERLAP_THR, 16'h8000);
		random_sets(12, 8);
		settle();

		if (mismatches == 0 && kept_expected.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
